/* src/dual_wheel_incremental_speed_loop_assert.svh */
// Assertion macros used by the checker file.
`ifndef DUAL_WHEEL_INCREMENTAL_SPEED_LOOP_ASSERT_SVH
`define DUAL_WHEEL_INCREMENTAL_SPEED_LOOP_ASSERT_SVH

// Checked only outside reset.
`define DWISL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dwisl check failed");

// Checked on every edge, reset included.
`define DWISL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dwisl check failed");

`endif

/* src/dwisl_pkg.sv */
package dwisl_pkg;

  localparam int GAIN_FRAC_BITS = 16;

  localparam int COUNT_W  = 16;
  localparam int GAIN_W   = 24;
  localparam int LIMIT_W  = 15;
  localparam int TARGET_W = 15;
  localparam int PERIOD_W = 16;
  localparam int DRIVE_W  = 16;

  localparam int ERR_W    = COUNT_W + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
  localparam int SUM_W    = PROD_D_W + 1;
  localparam int INC_W    = SUM_W - GAIN_FRAC_BITS;
  localparam int ACC_W    = INC_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [GAIN_W-1:0]   KP_RESET     = 24'd458752;
  localparam logic [GAIN_W-1:0]   KD_RESET     = 24'd197;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 15'd7199;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd280;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP     = 3'd0,
    CFG_KD     = 3'd1,
    CFG_LIMIT  = 3'd2,
    CFG_TARGET = 3'd3,
    CFG_PERIOD = 3'd4
  } cfg_idx_t;

  // Load strobes of the four pipeline stages.
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
    logic ld_d;
  } adv_t;

endpackage

/* src/dual_wheel_incremental_speed_loop.sv */
// Throughput: one word per cycle while the output is not stalled; four pipeline
// stages (error, gain products, scaled sum, accumulate and clamp), the output
// stage holds a word until taken.
// Reset (synchronous, rst high): pipeline emptied, tick counter, direction,
// accumulators and stored errors cleared, configuration back to its defaults.
module dual_wheel_incremental_speed_loop (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [31:0]                           s_axis_tdata,  // left_count, right_count
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [31:0]                           m_axis_tdata,  // left_drive, right_drive
  output logic                                  m_axis_tuser,  // moving_backward
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dwisl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwisl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [dwisl_pkg::GAIN_W-1:0]   kp_gain;
  logic [dwisl_pkg::GAIN_W-1:0]   kd_gain;
  logic [dwisl_pkg::LIMIT_W-1:0]  pwm_limit;
  logic [dwisl_pkg::TARGET_W-1:0] target_counts;
  logic [dwisl_pkg::PERIOD_W-1:0] flip_period;

  logic v_a, v_b, v_c, v_d;
  logic b_a, b_b, b_c, b_d;
  logic free_a, free_b, free_c, free_d;
  dwisl_pkg::adv_t adv;

  logic                                backward_now;
  logic signed [dwisl_pkg::ERR_W-1:0]  target;
  logic signed [dwisl_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dwisl_pkg::DRIVE_W-1:0] right_drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain       <= dwisl_pkg::KP_RESET;
      kd_gain       <= dwisl_pkg::KD_RESET;
      pwm_limit     <= dwisl_pkg::LIMIT_RESET;
      target_counts <= dwisl_pkg::TARGET_RESET;
      flip_period   <= dwisl_pkg::PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dwisl_pkg::CFG_KP:     kp_gain       <= cfg_data;
        dwisl_pkg::CFG_KD:     kd_gain       <= cfg_data;
        dwisl_pkg::CFG_LIMIT:  pwm_limit     <= cfg_data[dwisl_pkg::LIMIT_W-1:0];
        dwisl_pkg::CFG_TARGET: target_counts <= cfg_data[dwisl_pkg::TARGET_W-1:0];
        dwisl_pkg::CFG_PERIOD: flip_period   <= cfg_data[dwisl_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it has room or its word moves on in the same cycle
  always_comb begin
    free_d   = !v_d || m_axis_tready;
    adv.ld_d = v_c && free_d;
    free_c   = !v_c || adv.ld_d;
    adv.ld_c = v_b && free_c;
    free_b   = !v_b || adv.ld_c;
    adv.ld_b = v_a && free_b;
    free_a   = !v_a || adv.ld_b;
    adv.ld_a = s_axis_tvalid && free_a;
  end

  assign s_axis_tready = free_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      if (adv.ld_a) v_a <= 1'b1; else if (adv.ld_b) v_a <= 1'b0;
      if (adv.ld_b) v_b <= 1'b1; else if (adv.ld_c) v_b <= 1'b0;
      if (adv.ld_c) v_c <= 1'b1; else if (adv.ld_d) v_c <= 1'b0;
      if (adv.ld_d) v_d <= 1'b1; else if (m_axis_tready) v_d <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld_a) b_a <= backward_now;
    if (adv.ld_b) b_b <= b_a;
    if (adv.ld_c) b_c <= b_b;
    if (adv.ld_d) b_d <= b_c;
  end

  dwisl_dir u_dir (
    .clk           (clk),
    .rst           (rst),
    .accept        (adv.ld_a),
    .period        (flip_period),
    .target_counts (target_counts),
    .backward_now  (backward_now),
    .target        (target)
  );

  dwisl_wheel u_left (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .kp_gain   (kp_gain),
    .kd_gain   (kd_gain),
    .pwm_limit (pwm_limit),
    .target    (target),
    .count     ($signed(s_axis_tdata[15:0])),
    .drive     (left_drive)
  );

  dwisl_wheel u_right (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .kp_gain   (kp_gain),
    .kd_gain   (kd_gain),
    .pwm_limit (pwm_limit),
    .target    (target),
    .count     ($signed(s_axis_tdata[31:16])),
    .drive     (right_drive)
  );

  assign m_axis_tvalid = v_d;
  assign m_axis_tdata  = {right_drive, left_drive};
  assign m_axis_tuser  = b_d;

endmodule

/* src/dwisl_dir.sv */
module dwisl_dir (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [dwisl_pkg::PERIOD_W-1:0]         period,
  input  logic [dwisl_pkg::TARGET_W-1:0]         target_counts,
  output logic                                   backward_now,
  output logic signed [dwisl_pkg::ERR_W-1:0]     target
);

  logic [dwisl_pkg::PERIOD_W-1:0] tick_cnt;
  logic                           backward;
  logic [dwisl_pkg::PERIOD_W-1:0] cnt_inc;
  logic                           flip;
  logic signed [dwisl_pkg::ERR_W-1:0] tc_s;

  always_comb begin
    cnt_inc      = tick_cnt + 1'b1;
    flip         = (cnt_inc >= period);
    backward_now = backward ^ flip;
    tc_s         = $signed({2'b00, target_counts});
    target       = backward_now ? -tc_s : tc_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_cnt <= '0;
      backward <= 1'b0;
    end else if (accept) begin
      tick_cnt <= flip ? '0 : cnt_inc;
      backward <= backward_now;
    end
  end

endmodule

/* src/dwisl_wheel.sv */
module dwisl_wheel (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dwisl_pkg::adv_t                        adv,
  input  logic [dwisl_pkg::GAIN_W-1:0]           kp_gain,
  input  logic [dwisl_pkg::GAIN_W-1:0]           kd_gain,
  input  logic [dwisl_pkg::LIMIT_W-1:0]          pwm_limit,
  input  logic signed [dwisl_pkg::ERR_W-1:0]     target,
  input  logic signed [dwisl_pkg::COUNT_W-1:0]   count,
  output logic signed [dwisl_pkg::DRIVE_W-1:0]   drive
);

  localparam int FB = dwisl_pkg::GAIN_FRAC_BITS;

  logic signed [dwisl_pkg::ERR_W-1:0]    last_err;
  logic signed [dwisl_pkg::ERR_W-1:0]    err_now;
  logic signed [dwisl_pkg::DIFF_W-1:0]   diff_now;
  logic signed [dwisl_pkg::ERR_W-1:0]    err_a;
  logic signed [dwisl_pkg::DIFF_W-1:0]   diff_a;
  logic signed [dwisl_pkg::GAIN_W:0]     kp_s;
  logic signed [dwisl_pkg::GAIN_W:0]     kd_s;
  logic signed [dwisl_pkg::PROD_P_W-1:0] prod_p;
  logic signed [dwisl_pkg::PROD_D_W-1:0] prod_d;
  logic signed [dwisl_pkg::SUM_W-1:0]    sum;
  logic signed [dwisl_pkg::SUM_W-1:0]    biased;
  logic signed [dwisl_pkg::INC_W-1:0]    inc;
  logic signed [dwisl_pkg::ACC_W-1:0]    acc_sum;
  logic signed [dwisl_pkg::ACC_W-1:0]    lim;
  logic signed [dwisl_pkg::DRIVE_W-1:0]  acc;
  logic signed [dwisl_pkg::DRIVE_W-1:0]  acc_next;

  // stage A: error and its change since the previous word
  always_comb begin
    err_now  = target - dwisl_pkg::ERR_W'(count);
    diff_now = dwisl_pkg::DIFF_W'(err_now) - dwisl_pkg::DIFF_W'(last_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
    end else if (adv.ld_a) begin
      last_err <= err_now;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld_a) begin
      err_a  <= err_now;
      diff_a <= diff_now;
    end
  end

  // stage B: gain products
  always_comb begin
    kp_s = $signed({1'b0, kp_gain});
    kd_s = $signed({1'b0, kd_gain});
  end

  always_ff @(posedge clk) begin
    if (adv.ld_b) begin
      prod_p <= dwisl_pkg::PROD_P_W'(kp_s) * dwisl_pkg::PROD_P_W'(err_a);
      prod_d <= dwisl_pkg::PROD_D_W'(kd_s) * dwisl_pkg::PROD_D_W'(diff_a);
    end
  end

  // stage C: weighted sum, scaled down with truncation toward zero
  always_comb begin
    sum    = dwisl_pkg::SUM_W'(prod_p) + dwisl_pkg::SUM_W'(prod_d);
    biased = sum + $signed({{(dwisl_pkg::SUM_W-FB){1'b0}}, {FB{sum[dwisl_pkg::SUM_W-1]}}});
  end

  always_ff @(posedge clk) begin
    if (adv.ld_c) begin
      inc <= dwisl_pkg::INC_W'(biased >>> FB);
    end
  end

  // stage D: accumulate and clamp to the symmetric limit
  always_comb begin
    acc_sum = dwisl_pkg::ACC_W'(acc) + dwisl_pkg::ACC_W'(inc);
    lim     = $signed({{(dwisl_pkg::ACC_W-dwisl_pkg::LIMIT_W){1'b0}}, pwm_limit});
    if (acc_sum > lim) begin
      acc_next = dwisl_pkg::DRIVE_W'(lim);
    end else if (acc_sum < -lim) begin
      acc_next = dwisl_pkg::DRIVE_W'(-lim);
    end else begin
      acc_next = dwisl_pkg::DRIVE_W'(acc_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv.ld_d) begin
      acc <= acc_next;
    end
  end

  assign drive = acc;

endmodule

/* src/dwisl_checker.sv */
`include "dual_wheel_incremental_speed_loop_assert.svh"

module dwisl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // no word comes out of reset
  `DWISL_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid)

  // input backs up only when the whole pipeline sits behind a stalled output
  `DWISL_ASSERT(a_full_only_on_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

  // clamped drives never reach the most negative code
  `DWISL_ASSERT(a_drive_range,
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000)

  // a stalled word holds
  `DWISL_ASSERT(a_out_hold,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))

endmodule

bind dual_wheel_incremental_speed_loop dwisl_checker u_dwisl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* dv/dual_wheel_incremental_speed_loop_tb.sv */
`timescale 1ns / 100ps

typedef struct {
  logic signed [dwisl_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dwisl_pkg::DRIVE_W-1:0] right_drive;
  logic                                 moving_backward;
} drive_word_t;

// Speed loop predictor plus the queue of drive words still owed by the block.
class drive_scoreboard;
  logic [dwisl_pkg::GAIN_W-1:0]   kp     = dwisl_pkg::KP_RESET;
  logic [dwisl_pkg::GAIN_W-1:0]   kd     = dwisl_pkg::KD_RESET;
  logic [dwisl_pkg::LIMIT_W-1:0]  limit  = dwisl_pkg::LIMIT_RESET;
  logic [dwisl_pkg::TARGET_W-1:0] target = dwisl_pkg::TARGET_RESET;
  logic [dwisl_pkg::PERIOD_W-1:0] period = dwisl_pkg::PERIOD_RESET;

  logic [dwisl_pkg::PERIOD_W-1:0] ticks = '0;
  logic                           backward = 1'b0;
  longint left_acc = 0, right_acc = 0;
  longint left_err = 0, right_err = 0;

  drive_word_t expected_drives[$];
  int mismatches = 0;

  function void write_reg(logic [dwisl_pkg::CFG_IDX_W-1:0] idx,
                          logic [dwisl_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      dwisl_pkg::CFG_KP:     kp = value;
      dwisl_pkg::CFG_KD:     kd = value;
      dwisl_pkg::CFG_LIMIT:  limit = value[dwisl_pkg::LIMIT_W-1:0];
      dwisl_pkg::CFG_TARGET: target = value[dwisl_pkg::TARGET_W-1:0];
      dwisl_pkg::CFG_PERIOD: period = value[dwisl_pkg::PERIOD_W-1:0];
      default: ;
    endcase
  endfunction

  // Gains are Q8.16, so products carry 16 fraction bits; drop them with truncation toward zero.
  function longint trunc_scale(longint weighted);
    if (weighted < 0)
      return -((-weighted) >> dwisl_pkg::GAIN_FRAC_BITS);
    return weighted >> dwisl_pkg::GAIN_FRAC_BITS;
  endfunction

  function longint wheel_drive(longint goal, longint count, inout longint acc,
                               inout longint last_err);
    longint err, weighted, next_acc, bound;
    err = goal - count;
    weighted = longint'(kp) * err + longint'(kd) * (err - last_err);
    next_acc = acc + trunc_scale(weighted);
    bound = longint'(limit);
    if (next_acc > bound) next_acc = bound;
    else if (next_acc < -bound) next_acc = -bound;
    acc = next_acc;
    last_err = err;
    return next_acc;
  endfunction

  function void note_tick(logic signed [dwisl_pkg::COUNT_W-1:0] left_count,
                          logic signed [dwisl_pkg::COUNT_W-1:0] right_count);
    longint goal;
    drive_word_t word;
    ticks = ticks + 1'b1;
    if (ticks >= period) begin
      ticks = '0;
      backward = !backward;
    end
    goal = backward ? -longint'(target) : longint'(target);
    word.left_drive = dwisl_pkg::DRIVE_W'(wheel_drive(goal, longint'(left_count), left_acc,
                                                      left_err));
    word.right_drive = dwisl_pkg::DRIVE_W'(wheel_drive(goal, longint'(right_count),
                                                       right_acc, right_err));
    word.moving_backward = backward;
    expected_drives.push_back(word);
  endfunction

  function void compare_field(string field, longint want, longint got);
    if (want == got) return;
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
  endfunction

  function void check_drive(logic [2*dwisl_pkg::DRIVE_W-1:0] data, logic backward_flag);
    drive_word_t want;
    if (expected_drives.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: drive word with none expected: %h / %b", $time, data, backward_flag);
      return;
    end
    want = expected_drives.pop_front();
    compare_field("left_drive", longint'(want.left_drive),
                  longint'($signed(data[dwisl_pkg::DRIVE_W-1:0])));
    compare_field("right_drive", longint'(want.right_drive),
                  longint'($signed(data[2*dwisl_pkg::DRIVE_W-1:dwisl_pkg::DRIVE_W])));
    compare_field("moving_backward", longint'(want.moving_backward),
                  longint'(backward_flag));
  endfunction
endclass

module dual_wheel_incremental_speed_loop_tb;

  localparam int PIPE_LATENCY = 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_TICKS   = 150;
  localparam int STYLE_RANDOM = 0;
  localparam int STYLE_MAX    = 1;
  localparam int STYLE_MIN    = 2;
  localparam longint COUNT_MAX = 32767;
  localparam longint COUNT_MIN = -32768;
  localparam int CW = dwisl_pkg::COUNT_W;
  localparam int DW = dwisl_pkg::CFG_DATA_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dwisl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dwisl_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  drive_scoreboard sb = new;

  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int unsigned out_stall = 0;
  int unsigned out_draw;
  int unsigned idle_cycles = 0;

  dual_wheel_incremental_speed_loop DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drive word sink with a random stall before each word.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_stall <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sb.check_drive(m_axis_tdata, m_axis_tuser);
      out_draw = quiet_out ? 0 : $urandom_range(0, 5);
      out_stall <= out_draw;
      m_axis_tready <= (out_draw == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_axis_tready <= (out_stall == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // tvalid stays high after a word so back-to-back words need no second assignment.
  task automatic send_tick(logic signed [dwisl_pkg::COUNT_W-1:0] left_count,
                           logic signed [dwisl_pkg::COUNT_W-1:0] right_count);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {right_count, left_count};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(left_count, right_count);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_reg(logic [dwisl_pkg::CFG_IDX_W-1:0] idx,
                         logic [dwisl_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits get random content; the block must ignore them.
  function automatic logic [dwisl_pkg::CFG_DATA_W-1:0] with_noise(
      logic [dwisl_pkg::CFG_DATA_W-1:0] value, int width);
    logic [dwisl_pkg::CFG_DATA_W-1:0] mask;
    mask = (DW'(1) << width) - 1'b1;
    return (DW'($urandom) & ~mask) | (value & mask);
  endfunction

  task automatic load_settings(int style);
    logic [dwisl_pkg::GAIN_W-1:0]   kp_val;
    logic [dwisl_pkg::GAIN_W-1:0]   kd_val;
    logic [dwisl_pkg::LIMIT_W-1:0]  limit_val;
    logic [dwisl_pkg::TARGET_W-1:0] target_val;
    logic [dwisl_pkg::PERIOD_W-1:0] period_val;
    case (style)
      STYLE_MAX: begin
        kp_val = '1; kd_val = '1; limit_val = '1; target_val = '1; period_val = '1;
      end
      STYLE_MIN: begin
        kp_val = '0; kd_val = '0; limit_val = '0; target_val = '0;
        period_val = dwisl_pkg::PERIOD_W'(1);
      end
      default: begin
        kp_val = dwisl_pkg::GAIN_W'($urandom_range(0, 1 << 20));
        kd_val = dwisl_pkg::GAIN_W'($urandom_range(0, 1 << 17));
        limit_val = ($urandom_range(0, 4) == 0) ? '1 : dwisl_pkg::LIMIT_W'($urandom);
        target_val = $urandom_range(0, 1) ? dwisl_pkg::TARGET_W'($urandom_range(0, 1000))
                                          : dwisl_pkg::TARGET_W'($urandom);
        period_val = ($urandom_range(0, 5) == 0) ? dwisl_pkg::PERIOD_W'($urandom)
                                                 : dwisl_pkg::PERIOD_W'($urandom_range(1, 120));
      end
    endcase
    wait_quiet();
    set_reg(dwisl_pkg::CFG_KP, kp_val);
    set_reg(dwisl_pkg::CFG_KD, kd_val);
    set_reg(dwisl_pkg::CFG_LIMIT, with_noise(DW'(limit_val), dwisl_pkg::LIMIT_W));
    set_reg(dwisl_pkg::CFG_TARGET, with_noise(DW'(target_val), dwisl_pkg::TARGET_W));
    set_reg(dwisl_pkg::CFG_PERIOD, with_noise(DW'(period_val), dwisl_pkg::PERIOD_W));
  endtask

  // Mostly counts close to the current target, some full range, some extremes.
  function automatic logic signed [dwisl_pkg::COUNT_W-1:0] pick_count();
    int unsigned pick;
    longint aim;
    pick = $urandom_range(0, 9);
    aim = sb.backward ? -longint'(sb.target) : longint'(sb.target);
    if (pick < 7) begin
      aim = aim + longint'($urandom_range(0, 128)) - 64;
      if (aim > COUNT_MAX) aim = COUNT_MAX;
      else if (aim < COUNT_MIN) aim = COUNT_MIN;
      return CW'(aim);
    end
    if (pick < 9) return CW'($urandom);
    case ($urandom_range(0, 3))
      0: return CW'(COUNT_MAX);
      1: return CW'(COUNT_MIN);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults straight out of reset
    send_tick(CW'(0), CW'(0));
    send_tick(16'sh7fff, 16'sh7fff);
    send_tick(16'sh8000, 16'sh8000);
    send_tick(16'sh7fff, 16'sh8000);
    send_tick(16'sh0118, 16'sh0118);

    // full-scale gains and bounds, fast reversals
    wait_quiet();
    set_reg(dwisl_pkg::CFG_KP, '1);
    set_reg(dwisl_pkg::CFG_KD, '1);
    set_reg(dwisl_pkg::CFG_LIMIT, DW'(COUNT_MAX));
    set_reg(dwisl_pkg::CFG_TARGET, DW'(COUNT_MAX));
    set_reg(dwisl_pkg::CFG_PERIOD, DW'(3));
    send_tick(16'sh8000, 16'sh7fff);
    send_tick(16'sh7fff, 16'sh8000);
    send_tick(16'sh8000, 16'sh8000);
    send_tick(CW'(0), CW'(0));

    // bound dropped under the saturated accumulators
    wait_quiet();
    set_reg(dwisl_pkg::CFG_LIMIT, DW'(100));
    send_tick(CW'(0), CW'(0));

    // period dropped under the running tick count
    wait_quiet();
    set_reg(dwisl_pkg::CFG_PERIOD, '1);
    send_tick(CW'(1), CW'(-1));
    send_tick(CW'(-1), CW'(1));
    send_tick(CW'(5), CW'(5));
    wait_quiet();
    set_reg(dwisl_pkg::CFG_PERIOD, DW'(2));
    send_tick(CW'(0), CW'(0));

    // zero period: reversal on every tick
    wait_quiet();
    set_reg(dwisl_pkg::CFG_PERIOD, '0);
    send_tick(CW'(10), CW'(-10));
    send_tick(CW'(-10), CW'(10));

    // zero bound pins both drives at zero
    wait_quiet();
    set_reg(dwisl_pkg::CFG_LIMIT, '0);
    send_tick(16'sh8000, 16'sh7fff);
    send_tick(16'sh7fff, 16'sh8000);

    // writes to unmapped indexes change nothing
    wait_quiet();
    for (int i = int'(dwisl_pkg::CFG_PERIOD) + 1; i < (1 << dwisl_pkg::CFG_IDX_W); i++)
      set_reg(dwisl_pkg::CFG_IDX_W'(i), '1);
    send_tick(CW'(3), CW'(3));

    // small negative sums must truncate toward zero, not floor
    wait_quiet();
    set_reg(dwisl_pkg::CFG_KP, DW'(1));
    set_reg(dwisl_pkg::CFG_KD, '0);
    set_reg(dwisl_pkg::CFG_TARGET, '0);
    set_reg(dwisl_pkg::CFG_LIMIT, DW'(1000));
    set_reg(dwisl_pkg::CFG_PERIOD, DW'(dwisl_pkg::PERIOD_RESET));
    send_tick(CW'(3), CW'(-3));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_settings(ph == 1 ? STYLE_MAX : (ph == 4 ? STYLE_MIN : STYLE_RANDOM));
      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      repeat (PHASE_TICKS) send_tick(pick_count(), pick_count());
    end

    quiet_out = 1'b0;
    wait_quiet();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_drives.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
